### design/owdm_pkg.sv
// Package for the omni wheel drive mixer: payload types, constants, sine table builder.
`timescale 1ns / 1ps

package owdm_pkg;

   localparam int ANGLE_STEPS   = 360;
   localparam int QUARTER_DEG   = 90;
   localparam int SINE_MAX_W    = 25;
   localparam int SINE_IDX_W    = 7;
   localparam int ANGLE_W       = 9;
   localparam int ANGLE_SUM_W   = 10;
   localparam int SPEED_W       = 8;
   localparam int DUTY_W        = 8;

   localparam logic [ANGLE_SUM_W-1:0] WHEEL1_OFFSET  = 10'd180;
   localparam logic [ANGLE_SUM_W-1:0] WHEEL2_OFFSET  = 10'd60;
   localparam logic [ANGLE_SUM_W-1:0] WHEEL3_OFFSET  = 10'd300;
   localparam logic [SPEED_W-1:0]     W2_OFFSET_RST  = 8'd30;
   localparam logic [63:0]            DEG_TO_RAD_Q30 = 64'd18740330;
   localparam logic [63:0]            Q30_ONE        = 64'd1 << 30;

   typedef struct packed {
      logic [ANGLE_W-1:0] heading_deg;
      logic [SPEED_W-1:0] drive_speed;
   } req_payload_type;

   typedef struct packed {
      logic              w1_in_a;
      logic              w1_in_b;
      logic [DUTY_W-1:0] w1_duty;
      logic              w2_in_a;
      logic              w2_in_b;
      logic [DUTY_W-1:0] w2_duty;
      logic              w3_in_a;
      logic              w3_in_b;
      logic [DUTY_W-1:0] w3_duty;
      logic              saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic              neg;
      logic [DUTY_W-1:0] duty;
      logic              sat;
   } wheel_cmd_type;

   typedef logic [SINE_MAX_W-1:0] sine_table_type [0:QUARTER_DEG];

   // First-quadrant sine, Taylor form in Q30, rounded to frac fraction bits.
   function automatic sine_table_type sine_table_build(input int frac);
      sine_table_type tab;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    t;
      logic [63:0]    s30;
      logic [63:0]    v;
      for (int k = 0; k <= QUARTER_DEG; k++) begin
         x   = 64'(k) * DEG_TO_RAD_Q30;
         x2  = (x * x) >> 30;
         t   = Q30_ONE;
         t   = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
         t   = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
         t   = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
         t   = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
         t   = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
         s30 = (x * t) >> 30;
         v   = (s30 + (64'd1 << (29 - frac))) >> (30 - frac);
         tab[k] = v[SINE_MAX_W-1:0];
      end
      return tab;
   endfunction

endpackage

### design/owdm_wheel.sv
// One wheel command: angle fold, sine lookup, speed scaling, sign and duty saturation.
`timescale 1ns / 1ps

module owdm_wheel #(
   parameter int SINE_FRAC_BITS = 15
) (
   input  logic [owdm_pkg::ANGLE_SUM_W-1:0] angle_sum,
   input  logic [owdm_pkg::SPEED_W-1:0]     speed_mag,
   input  logic                             speed_neg,
   output owdm_pkg::wheel_cmd_type          cmd
);

   localparam int SINE_W = SINE_FRAC_BITS + 1;
   localparam int PROD_W = owdm_pkg::SPEED_W + SINE_W;
   localparam int MAG_W  = PROD_W - SINE_FRAC_BITS;

   localparam owdm_pkg::sine_table_type SINE_TABLE =
      owdm_pkg::sine_table_build(SINE_FRAC_BITS);

   localparam logic [owdm_pkg::ANGLE_SUM_W-1:0] STEPS_W =
      owdm_pkg::ANGLE_SUM_W'(owdm_pkg::ANGLE_STEPS);
   localparam logic [owdm_pkg::ANGLE_W-1:0] DEG90  = 9'd90;
   localparam logic [owdm_pkg::ANGLE_W-1:0] DEG180 = 9'd180;
   localparam logic [owdm_pkg::ANGLE_W-1:0] DEG270 = 9'd270;
   localparam logic [owdm_pkg::ANGLE_W-1:0] DEG360 = 9'd360;

   logic [owdm_pkg::ANGLE_SUM_W-1:0] angle_red;
   logic [owdm_pkg::ANGLE_W-1:0]     angle;
   logic [owdm_pkg::ANGLE_W-1:0]     idx_wide;
   logic [owdm_pkg::SINE_IDX_W-1:0]  idx;
   logic                             sine_neg;
   logic [SINE_W-1:0]                sine_mag;
   logic [PROD_W-1:0]                prod;
   logic [MAG_W-1:0]                 mag;

   assign angle_red = (angle_sum >= STEPS_W) ? angle_sum - STEPS_W : angle_sum;
   assign angle     = angle_red[owdm_pkg::ANGLE_W-1:0];

   always_comb begin
      if (angle <= DEG90) begin
         idx_wide = angle;
         sine_neg = 1'b0;
      end else if (angle <= DEG180) begin
         idx_wide = DEG180 - angle;
         sine_neg = 1'b0;
      end else if (angle <= DEG270) begin
         idx_wide = angle - DEG180;
         sine_neg = 1'b1;
      end else begin
         idx_wide = DEG360 - angle;
         sine_neg = 1'b1;
      end
   end

   assign idx      = idx_wide[owdm_pkg::SINE_IDX_W-1:0];
   assign sine_mag = SINE_TABLE[idx][SINE_W-1:0];
   assign prod     = PROD_W'(speed_mag) * PROD_W'(sine_mag);
   assign mag      = prod[PROD_W-1:SINE_FRAC_BITS];

   always_comb begin
      if (mag == '0) begin
         cmd.neg  = 1'b0;
         cmd.duty = owdm_pkg::DUTY_W'(1);
         cmd.sat  = 1'b0;
      end else if (mag > MAG_W'({owdm_pkg::DUTY_W{1'b1}})) begin
         cmd.neg  = (sine_neg == speed_neg);
         cmd.duty = {owdm_pkg::DUTY_W{1'b1}};
         cmd.sat  = 1'b1;
      end else begin
         cmd.neg  = (sine_neg == speed_neg);
         cmd.duty = mag[owdm_pkg::DUTY_W-1:0];
         cmd.sat  = 1'b0;
      end
   end

endmodule

### design/omni_wheel_drive_mixer.sv
// Top level of the three-wheel omni drive mixer.
// A req transaction reaches rsp valid via the input register, then the result register.
// Throughput: one transaction per cycle unless rsp_ready stalls; each wheel's sine
// lookup and 8-bit scaling multiply sit in the single stage between the two registers.
// Reset (synchronous, active high) empties both stages and sets the wheel two
// speed offset to 30.
`timescale 1ns / 1ps

module omni_wheel_drive_mixer #(
   parameter int SINE_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  owdm_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output owdm_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_wr_en,
   input  logic [owdm_pkg::SPEED_W-1:0]      csr_wr_data
);

   localparam logic [owdm_pkg::ANGLE_W-1:0] STEPS_9 =
      owdm_pkg::ANGLE_W'(owdm_pkg::ANGLE_STEPS);

   logic                             s0_valid_ff, s0_valid_in;
   owdm_pkg::req_payload_type        s0_data_ff, s0_data_in;
   logic                             out_valid_ff, out_valid_in;
   owdm_pkg::rsp_payload_type        out_data_ff, out_data_in;
   logic [owdm_pkg::SPEED_W-1:0]     offset_ff, offset_in;

   logic                             out_load;
   logic                             req_take;
   logic [owdm_pkg::ANGLE_W-1:0]     heading;
   logic [owdm_pkg::ANGLE_SUM_W-1:0] hd_ext;
   logic [owdm_pkg::SPEED_W:0]       speed2;
   logic                             speed2_neg;
   logic [owdm_pkg::SPEED_W-1:0]     speed2_mag;
   owdm_pkg::wheel_cmd_type          cmd1, cmd2, cmd3;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !s0_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   assign heading = (s0_data_ff.heading_deg >= STEPS_9) ?
                    s0_data_ff.heading_deg - STEPS_9 : s0_data_ff.heading_deg;
   assign hd_ext  = owdm_pkg::ANGLE_SUM_W'(heading);

   assign speed2     = {1'b0, s0_data_ff.drive_speed} - {1'b0, offset_ff};
   assign speed2_neg = speed2[owdm_pkg::SPEED_W];
   assign speed2_mag = speed2_neg ? offset_ff - s0_data_ff.drive_speed
                                  : speed2[owdm_pkg::SPEED_W-1:0];

   owdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel1 (
      .angle_sum (hd_ext + owdm_pkg::WHEEL1_OFFSET),
      .speed_mag (s0_data_ff.drive_speed),
      .speed_neg (1'b0),
      .cmd       (cmd1)
   );

   owdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel2 (
      .angle_sum (hd_ext + owdm_pkg::WHEEL2_OFFSET),
      .speed_mag (speed2_mag),
      .speed_neg (speed2_neg),
      .cmd       (cmd2)
   );

   owdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel3 (
      .angle_sum (hd_ext + owdm_pkg::WHEEL3_OFFSET),
      .speed_mag (s0_data_ff.drive_speed),
      .speed_neg (1'b0),
      .cmd       (cmd3)
   );

   always_comb begin
      out_data_in.w1_in_a   = cmd1.neg;
      out_data_in.w1_in_b   = !cmd1.neg;
      out_data_in.w1_duty   = cmd1.duty;
      out_data_in.w2_in_a   = !cmd2.neg;
      out_data_in.w2_in_b   = cmd2.neg;
      out_data_in.w2_duty   = cmd2.duty;
      out_data_in.w3_in_a   = !cmd3.neg;
      out_data_in.w3_in_b   = cmd3.neg;
      out_data_in.w3_duty   = cmd3.duty;
      out_data_in.saturated = cmd1.sat || cmd2.sat || cmd3.sat;
   end

   assign s0_valid_in  = req_take ? 1'b1 : (out_load ? 1'b0 : s0_valid_ff);
   assign s0_data_in   = req_take ? req_data : s0_data_ff;
   assign out_valid_in = out_load ? s0_valid_ff : out_valid_ff;
   assign offset_in    = csr_wr_en ? csr_wr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         offset_ff    <= owdm_pkg::W2_OFFSET_RST;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         out_valid_ff <= out_valid_in;
         offset_ff    <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_data_ff <= s0_data_in;
      if (out_load && s0_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
